// ----- design/rrs_pkg.sv -----
// Shared types and constants for the relative reference scanner.
// No dependencies; every other design file uses this package.
`timescale 1ns / 1ps
`default_nettype none

package rrs_pkg;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_NEW_SCAN      = 2'd0,
        KIND_SECTION_START = 2'd1,
        KIND_CODE_BYTE     = 2'd2,
        KIND_SECTION_END   = 2'd3
    } req_kind_t;

    // Result kinds
    localparam logic RES_HIT     = 1'b0;
    localparam logic RES_SUMMARY = 1'b1;

    // Configuration register indexes
    localparam int  CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOWN_LIMIT    = 1'b1;
    localparam int  CFG_DATA_W = 32;

    localparam logic [15:0] SHOWN_LIMIT_RESET = 16'd4096;
    localparam logic [31:0] SAT32             = 32'hFFFF_FFFF;
    localparam int          WINDOW_DEPTH      = 7;
    localparam int          MAX_SHOWN         = 3;

    typedef struct packed {
        req_kind_t   kind;
        logic [31:0] section_base;
        logic [7:0]  code_byte;
    } scan_req_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] hit_address;
        logic        tail_length;
        logic [7:0]  opcode_far;
        logic [7:0]  opcode_mid;
        logic [7:0]  opcode_near;
        logic [2:0]  opcode_valid;
        logic [31:0] section_hits;
        logic [31:0] total_hits;
    } scan_res_t;

endpackage

`default_nettype wire

// ----- design/rrs_if.sv -----
// Valid/ready channel interfaces for scanner requests and results.
// Depends on rrs_pkg for field types.
`timescale 1ns / 1ps
`default_nettype none

interface rrs_req_if;
    logic                valid;
    logic                ready;
    rrs_pkg::req_kind_t  kind;
    logic [31:0]         section_base;
    logic [7:0]          code_byte;

    modport source (output valid, kind, section_base, code_byte, input ready);
    modport sink   (input valid, kind, section_base, code_byte, output ready);
endinterface

interface rrs_res_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] hit_address;
    logic        tail_length;
    logic [7:0]  opcode_far;
    logic [7:0]  opcode_mid;
    logic [7:0]  opcode_near;
    logic [2:0]  opcode_valid;
    logic [31:0] section_hits;
    logic [31:0] total_hits;

    modport source (output valid, result_kind, hit_address, tail_length, opcode_far,
                    opcode_mid, opcode_near, opcode_valid, section_hits, total_hits,
                    input ready);
    modport sink   (input valid, result_kind, hit_address, tail_length, opcode_far,
                    opcode_mid, opcode_near, opcode_valid, section_hits, total_hits,
                    output ready);
endinterface

`default_nettype wire

// ----- design/rrs_in_reg.sv -----
// Input register stage: captures one request from the request channel.
// Depends on rrs_pkg and rrs_req_if.
`timescale 1ns / 1ps
`default_nettype none

module rrs_in_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    rrs_req_if.sink            req,
    input  wire logic          advance,
    output logic               item_valid,
    output rrs_pkg::scan_req_t item
);
    import rrs_pkg::*;

    logic      vld_reg;
    logic      vld_next;
    scan_req_t data_reg;

    // Free when empty or when the held request moves on this cycle
    assign req.ready = !vld_reg || advance;

    always_comb
    begin
        vld_next = vld_reg;
        if (req.ready)
        begin
            vld_next = req.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            data_reg.kind         <= req.kind;
            data_reg.section_base <= req.section_base;
            data_reg.code_byte    <= req.code_byte;
        end
    end

    assign item_valid = vld_reg;
    assign item       = data_reg;

endmodule

`default_nettype wire

// ----- design/rrs_scan_core.sv -----
// Scan core: byte window, section state, displacement match and hit counters.
// Depends on rrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrs_scan_core #(
    parameter int OPCODE_BYTES = 3
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire rrs_pkg::scan_req_t item,
    input  wire logic [31:0]        target_address,
    input  wire logic [15:0]        shown_limit,
    output logic                    res_load,
    output rrs_pkg::scan_res_t      res_data
);
    import rrs_pkg::*;

    localparam int SHOWN = (OPCODE_BYTES > MAX_SHOWN) ? MAX_SHOWN : OPCODE_BYTES;

    logic [7:0]  win_reg  [WINDOW_DEPTH];
    logic [7:0]  win_next [WINDOW_DEPTH];
    logic [31:0] pos_reg, pos_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] sect_reg, sect_next;
    logic [31:0] total_reg, total_next;

    logic [31:0] pos_inc;
    logic [31:0] sect_inc;
    logic [31:0] total_inc;
    logic [31:0] disp_raw;
    logic [34:0] sum0;
    logic [34:0] tgt_ext;
    logic [34:0] tgt_m1;
    logic        match0;
    logic        match1;
    logic        code_ok;
    logic        hit;
    logic        shown_ok;
    logic [7:0]  op_byte  [MAX_SHOWN];
    logic [2:0]  op_valid;

    // Window shift and saturating increments
    always_comb
    begin
        win_next[0] = item.code_byte;
        for (int i = 1; i < WINDOW_DEPTH; i++)
        begin
            win_next[i] = win_reg[i-1];
        end
        pos_inc   = (pos_reg == SAT32) ? pos_reg : pos_reg + 32'd1;
        sect_inc  = (sect_reg == SAT32) ? sect_reg : sect_reg + 32'd1;
        total_inc = (total_reg == SAT32) ? total_reg : total_reg + 32'd1;
    end

    // Target check: base + p + 4 + tail + disp, p + 4 being the new position
    always_comb
    begin
        disp_raw = {item.code_byte, win_reg[0], win_reg[1], win_reg[2]};
        sum0     = {3'b000, base_reg} + {3'b000, pos_inc} + {{3{disp_raw[31]}}, disp_raw};
        tgt_ext  = {3'b000, target_address};
        tgt_m1   = tgt_ext - 35'd1;
        match0   = (sum0 == tgt_ext);
        match1   = (sum0 == tgt_m1);
        code_ok  = |pos_inc[31:2];
        hit      = code_ok && (match0 || match1);
        shown_ok = (sect_inc <= {16'd0, shown_limit});
    end

    // Opcode bytes before the displacement; back b needs position >= 4 + b
    always_comb
    begin
        op_valid = 3'b000;
        for (int b = 1; b <= MAX_SHOWN; b++)
        begin
            op_byte[b-1] = 8'd0;
            if ((b <= SHOWN) && (pos_inc >= 32'(4 + b)))
            begin
                op_byte[b-1]  = win_reg[2+b];
                op_valid[b-1] = 1'b1;
            end
        end
    end

    // Next state and result
    always_comb
    begin
        pos_next   = pos_reg;
        base_next  = base_reg;
        sect_next  = sect_reg;
        total_next = total_reg;
        res_load   = 1'b0;
        res_data   = '0;
        unique case (item.kind)
            KIND_NEW_SCAN:
            begin
                total_next = 32'd0;
            end
            KIND_SECTION_START:
            begin
                base_next = item.section_base;
                pos_next  = 32'd0;
                sect_next = 32'd0;
            end
            KIND_CODE_BYTE:
            begin
                pos_next = pos_inc;
                if (hit)
                begin
                    sect_next  = sect_inc;
                    total_next = total_inc;
                    res_load   = advance && shown_ok;
                end
                res_data.result_kind  = RES_HIT;
                res_data.hit_address  = base_reg + pos_inc - 32'd4;
                res_data.tail_length  = !match0;
                res_data.opcode_near  = op_byte[0];
                res_data.opcode_mid   = op_byte[1];
                res_data.opcode_far   = op_byte[2];
                res_data.opcode_valid = op_valid;
                res_data.section_hits = sect_inc;
                res_data.total_hits   = total_inc;
            end
            KIND_SECTION_END:
            begin
                res_load              = advance && (|pos_reg[31:2]);
                res_data.result_kind  = RES_SUMMARY;
                res_data.section_hits = sect_reg;
                res_data.total_hits   = total_reg;
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                win_reg[i] <= 8'd0;
            end
            pos_reg   <= 32'd0;
            base_reg  <= 32'd0;
            sect_reg  <= 32'd0;
            total_reg <= 32'd0;
        end
        else if (advance)
        begin
            if (item.kind == KIND_SECTION_START)
            begin
                for (int i = 0; i < WINDOW_DEPTH; i++)
                begin
                    win_reg[i] <= 8'd0;
                end
            end
            else if (item.kind == KIND_CODE_BYTE)
            begin
                for (int i = 0; i < WINDOW_DEPTH; i++)
                begin
                    win_reg[i] <= win_next[i];
                end
            end
            pos_reg   <= pos_next;
            base_reg  <= base_next;
            sect_reg  <= sect_next;
            total_reg <= total_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/rrs_out_reg.sv -----
// Result register: holds one result until the result channel takes it.
// Depends on rrs_pkg and rrs_res_if.
`timescale 1ns / 1ps
`default_nettype none

module rrs_out_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire rrs_pkg::scan_res_t data,
    output logic                    space,
    rrs_res_if.source               res
);
    import rrs_pkg::*;

    logic      vld_reg;
    logic      vld_next;
    scan_res_t data_reg;

    // Slot is free when empty or being drained this cycle
    assign space = !vld_reg || res.ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (space)
        begin
            vld_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign res.valid        = vld_reg;
    assign res.result_kind  = data_reg.result_kind;
    assign res.hit_address  = data_reg.hit_address;
    assign res.tail_length  = data_reg.tail_length;
    assign res.opcode_far   = data_reg.opcode_far;
    assign res.opcode_mid   = data_reg.opcode_mid;
    assign res.opcode_near  = data_reg.opcode_near;
    assign res.opcode_valid = data_reg.opcode_valid;
    assign res.section_hits = data_reg.section_hits;
    assign res.total_hits   = data_reg.total_hits;

endmodule

`default_nettype wire

// ----- design/relative_reference_scanner_unit.sv -----
// Relative reference scanner, top level: config registers and stage wiring.
// Depends on rrs_pkg, rrs_if, rrs_in_reg, rrs_scan_core and rrs_out_reg.
//
// Usage:
//   req: one request per item: new scan, section start (with section_base),
//        code byte (with code_byte) or section end. Accepted on valid && ready.
//   rsp: at most one result per request: a reference hit for a code byte
//        whose displacement points at target_address, or a section summary.
//   cfg: cfg_we/cfg_index/cfg_wdata write target_address (0) and
//        shown_limit (1); write only while the scanner is idle.
// A request waits in the input register; its result is then loaded into the
// result register and shows on rsp. Throughput: one request per cycle while
// rsp does not stall, set by the single pass through the window shift, the
// 35-bit displacement add and compare and the counters.
// Reset clears the byte window, position, section base and both counters,
// sets target_address to 0 and shown_limit to 4096.
// When rsp stalls, the result register holds and the input register still
// takes one more request; further requests wait on req.ready.
`timescale 1ns / 1ps
`default_nettype none

module relative_reference_scanner_unit #(
    parameter int OPCODE_BYTES = 3
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    rrs_req_if.sink                              req,
    rrs_res_if.source                            rsp,
    input  wire logic                            cfg_we,
    input  wire logic [rrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rrs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import rrs_pkg::*;

    logic [31:0] target_addr_reg;
    logic [15:0] limit_reg;
    logic        item_valid;
    scan_req_t   item;
    logic        advance;
    logic        space;
    logic        res_load;
    scan_res_t   res_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_addr_reg <= 32'd0;
            limit_reg       <= SHOWN_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TARGET_ADDRESS: target_addr_reg <= cfg_wdata[31:0];
                CFG_SHOWN_LIMIT:    limit_reg       <= cfg_wdata[15:0];
                default:            limit_reg       <= limit_reg;
            endcase
        end
    end

    // Request moves into the core when the result slot can take its result
    assign advance = item_valid && space;

    rrs_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    rrs_scan_core #(
        .OPCODE_BYTES (OPCODE_BYTES)
    ) u_scan_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .item           (item),
        .target_address (target_addr_reg),
        .shown_limit    (limit_reg),
        .res_load       (res_load),
        .res_data       (res_data)
    );

    rrs_out_reg u_out_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (res_load),
        .data  (res_data),
        .space (space),
        .res   (rsp)
    );

endmodule

`default_nettype wire

// ----- dv/relative_reference_scanner_unit_test.sv -----
// Testbench for relative_reference_scanner_unit: directed and random scans checked
// against a behavioral scanner model, with random idling and back-pressure.
// Depends on rrs_pkg, rrs_if and the scanner RTL.
`timescale 1ns / 1ps

module relative_reference_scanner_unit_test;
    import rrs_pkg::*;

    localparam int OPCODE_BYTES_TB = 3;
    localparam int SHOWN_BYTES = (OPCODE_BYTES_TB > MAX_SHOWN) ? MAX_SHOWN : OPCODE_BYTES_TB;
    localparam int MAX_SECT_LEN = 48;
    localparam int DRAIN_LIMIT = 20000;
    localparam int MAX_PRINTED = 50;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    rrs_req_if req_bus ();
    rrs_res_if rsp_bus ();

    relative_reference_scanner_unit #(
        .OPCODE_BYTES (OPCODE_BYTES_TB)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Scanner model state and registers
    logic [7:0]  byte_hist [WINDOW_DEPTH];
    logic [31:0] sect_pos;
    logic [31:0] sect_base;
    logic [31:0] sect_hits;
    logic [31:0] scan_hits;
    logic [31:0] tgt_addr;
    logic [15:0] shown_max;

    scan_res_t expected_results [$];
    scan_res_t got_want;
    int error_count;
    int sent_items;
    int rx_hold_cycles;
    bit idle_on;

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Run limit
    initial
    begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_PRINTED)
            $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Append one expected result at the tail of the queue
    function automatic void queue_expected(input scan_res_t res);
        expected_results = {expected_results, res};
    endfunction

    // Model: apply one accepted request, queue the result it causes
    function automatic void scan_model_step(input req_kind_t k, input logic [31:0] base_in,
                                            input logic [7:0] byte_in);
        logic [31:0] p;
        logic [31:0] raw;
        longint disp;
        longint sum;
        bit matched;
        scan_res_t res;
        matched = 1'b0;
        res = '0;
        case (k)
            KIND_NEW_SCAN: scan_hits = '0;
            KIND_SECTION_START:
            begin
                sect_base = base_in;
                sect_pos = '0;
                sect_hits = '0;
                for (int i = 0; i < WINDOW_DEPTH; i++)
                    byte_hist[i] = '0;
            end
            KIND_SECTION_END:
            begin
                if (sect_pos >= 4)
                begin
                    res.result_kind = RES_SUMMARY;
                    res.section_hits = sect_hits;
                    res.total_hits = scan_hits;
                    queue_expected(res);
                end
            end
            default:
            begin
                for (int i = WINDOW_DEPTH - 1; i > 0; i--)
                    byte_hist[i] = byte_hist[i - 1];
                byte_hist[0] = byte_in;
                if (sect_pos != SAT32)
                    sect_pos++;
                if (sect_pos >= 4)
                begin
                    p = sect_pos - 4;
                    raw = {byte_hist[0], byte_hist[1], byte_hist[2], byte_hist[3]};
                    disp = {{32{raw[31]}}, raw};
                    for (int t = 0; t < 2 && !matched; t++)
                    begin
                        // exact sum, no 32-bit wrap
                        sum = longint'({32'd0, sect_base}) + longint'({32'd0, p})
                            + 4 + longint'(t) + disp;
                        if (sum == longint'({32'd0, tgt_addr}))
                        begin
                            matched = 1'b1;
                            if (sect_hits != SAT32)
                                sect_hits++;
                            if (scan_hits != SAT32)
                                scan_hits++;
                            if (sect_hits <= {16'd0, shown_max})
                            begin
                                res.result_kind = RES_HIT;
                                res.hit_address = sect_base + p;
                                res.tail_length = t[0];
                                if (SHOWN_BYTES >= 1 && p >= 1)
                                begin
                                    res.opcode_near = byte_hist[4];
                                    res.opcode_valid[0] = 1'b1;
                                end
                                if (SHOWN_BYTES >= 2 && p >= 2)
                                begin
                                    res.opcode_mid = byte_hist[5];
                                    res.opcode_valid[1] = 1'b1;
                                end
                                if (SHOWN_BYTES >= 3 && p >= 3)
                                begin
                                    res.opcode_far = byte_hist[6];
                                    res.opcode_valid[2] = 1'b1;
                                end
                                res.section_hits = sect_hits;
                                res.total_hits = scan_hits;
                                queue_expected(res);
                            end
                        end
                    end
                end
            end
        endcase
    endfunction

    // Idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one request; returns just after the edge that accepts it
    task automatic send_request(input req_kind_t k, input logic [31:0] base,
                                input logic [7:0] b);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.kind <= k;
        req_bus.section_base <= base;
        req_bus.code_byte <= b;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        scan_model_step(k, base, b);
        sent_items++;
    endtask

    task automatic release_request();
        @(negedge clk);
        req_bus.valid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        release_request();
        while (expected_results.size() != 0)
            @(posedge clk);
        // requests that cause no result may still be in flight
        repeat (4) @(posedge clk);
    endtask

    // Register write, only once the scanner is idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_results_drained();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        if (idx == CFG_TARGET_ADDRESS)
            tgt_addr = data;
        else
            shown_max = data[15:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_wdata <= $urandom;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_request(KIND_CODE_BYTE, $urandom, b);
    endtask

    // Random sections with displacements planted to point at the target
    task automatic scan_random_sections(input int n_items);
        logic [7:0] sect [MAX_SECT_LEN];
        logic [31:0] base;
        logic [31:0] d;
        int len;
        int r;
        int at;
        int tail;
        int stop_at;
        stop_at = sent_items + n_items;
        while (sent_items < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                send_request(KIND_NEW_SCAN, $urandom, 8'($urandom));
            else if (r < 22)
            begin
                repeat ($urandom_range(1, 3))
                    send_request(req_kind_t'($urandom_range(0, 3)), $urandom,
                                 8'($urandom));
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: base = tgt_addr - $urandom_range(0, 200);
                    1: base = $urandom;
                    2: base = 32'hFFFF_FFFF - $urandom_range(0, 40);
                    default: base = $urandom_range(0, 40);
                endcase
                r = $urandom_range(0, 99);
                if (r < 10)
                    len = $urandom_range(0, 3);
                else if (r < 85)
                    len = $urandom_range(4, 16);
                else
                    len = $urandom_range(17, MAX_SECT_LEN);
                for (int i = 0; i < len; i++)
                    sect[i] = 8'($urandom);
                if (len >= 4)
                begin
                    repeat ($urandom_range(0, 3))
                    begin
                        at = $urandom_range(0, len - 4);
                        tail = $urandom_range(0, 1);
                        d = tgt_addr - (base + at + 4 + tail);
                        sect[at] = d[7:0];
                        sect[at + 1] = d[15:8];
                        sect[at + 2] = d[23:16];
                        sect[at + 3] = d[31:24];
                    end
                end
                // now and then carry on in the previous section
                if ($urandom_range(0, 9) != 0)
                    send_request(KIND_SECTION_START, base, 8'($urandom));
                for (int i = 0; i < len; i++)
                    send_byte(sect[i]);
                r = $urandom_range(0, 99);
                if (r < 92)
                    send_request(KIND_SECTION_END, $urandom, 8'($urandom));
                if (r >= 80 && r < 92)
                    send_request(KIND_SECTION_END, $urandom, 8'($urandom));
            end
        end
    endtask

    // Reset settings: stray bytes, repeated and short section ends, wrap-only sum
    task automatic test_directed_basics();
        send_request(KIND_NEW_SCAN, 32'hFFFF_FFFF, 8'hFF);
        // base is zero after reset; displacement -4 hits at position 0
        send_byte(8'hFC);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_request(KIND_SECTION_END, 32'h0000_0000, 8'h00);
        send_request(KIND_SECTION_END, 32'hFFFF_FFFF, 8'hFF);
        send_request(KIND_SECTION_START, 32'h0000_0000, 8'h00);
        send_byte(8'hAA);
        send_byte(8'hBB);
        send_byte(8'hCC);
        send_request(KIND_SECTION_END, 32'h5555_5555, 8'h55);
        // tail 1 hit with all three opcode bytes inside the section
        send_byte(8'hF8);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_request(KIND_SECTION_END, 32'hAAAA_AAAA, 8'hAA);
        send_request(KIND_NEW_SCAN, 32'h0000_0000, 8'h00);
        // matches only modulo 2^32, never as an exact sum
        send_request(KIND_SECTION_START, 32'hFFFF_FFFF, 8'h00);
        send_byte(8'hFD);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_request(KIND_SECTION_END, 32'h0000_0000, 8'h00);
    endtask

    task automatic test_top_target_max_limit();
        write_register(CFG_TARGET_ADDRESS, 32'hFFFF_FFFF);
        write_register(CFG_SHOWN_LIMIT, 32'h0000_FFFF);
        scan_random_sections(150);
    endtask

    task automatic test_limit_one();
        write_register(CFG_TARGET_ADDRESS, $urandom);
        write_register(CFG_SHOWN_LIMIT, {16'($urandom_range(0, 65535)), 16'd1});
        scan_random_sections(150);
    endtask

    task automatic test_limit_zero();
        write_register(CFG_TARGET_ADDRESS, 32'h0000_0000);
        write_register(CFG_SHOWN_LIMIT, 32'h0000_0000);
        scan_random_sections(120);
    endtask

    // Receiver holds off long enough to fill the scanner and stall requests
    task automatic test_input_backpressure();
        write_register(CFG_TARGET_ADDRESS, $urandom);
        write_register(CFG_SHOWN_LIMIT, {16'hFFFF, SHOWN_LIMIT_RESET});
        rx_hold_cycles = 300;
        scan_random_sections(100);
        scan_random_sections(150);
    endtask

    task automatic test_back_to_back();
        write_register(CFG_TARGET_ADDRESS, $urandom);
        write_register(CFG_SHOWN_LIMIT, 32'd2);
        idle_on = 1'b0;
        scan_random_sections(200);
        idle_on = 1'b1;
    endtask

    // Result receiver with random stalls
    initial
    begin
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                rsp_bus.ready <= 1'b0;
                rx_hold_cycles--;
            end
            else if (stall > 0)
            begin
                rsp_bus.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result, hit_address", rsp_bus.hit_address, '0);
            else
            begin
                got_want = expected_results.pop_front();
                check_field("result_kind", 32'(rsp_bus.result_kind),
                            32'(got_want.result_kind));
                check_field("hit_address", rsp_bus.hit_address, got_want.hit_address);
                check_field("tail_length", 32'(rsp_bus.tail_length),
                            32'(got_want.tail_length));
                check_field("opcode_far", 32'(rsp_bus.opcode_far),
                            32'(got_want.opcode_far));
                check_field("opcode_mid", 32'(rsp_bus.opcode_mid),
                            32'(got_want.opcode_mid));
                check_field("opcode_near", 32'(rsp_bus.opcode_near),
                            32'(got_want.opcode_near));
                check_field("opcode_valid", 32'(rsp_bus.opcode_valid),
                            32'(got_want.opcode_valid));
                check_field("section_hits", rsp_bus.section_hits, got_want.section_hits);
                check_field("total_hits", rsp_bus.total_hits, got_want.total_hits);
            end
        end
    end

    // Main sequence
    initial
    begin
        int wait_cycles;
        error_count = 0;
        sent_items = 0;
        rx_hold_cycles = 0;
        idle_on = 1'b1;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_TARGET_ADDRESS;
        cfg_wdata = '0;
        req_bus.valid = 1'b0;
        req_bus.kind = KIND_NEW_SCAN;
        req_bus.section_base = '0;
        req_bus.code_byte = '0;
        rsp_bus.ready = 1'b0;
        // model reset state
        for (int i = 0; i < WINDOW_DEPTH; i++)
            byte_hist[i] = '0;
        sect_pos = '0;
        sect_base = '0;
        sect_hits = '0;
        scan_hits = '0;
        tgt_addr = '0;
        shown_max = SHOWN_LIMIT_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_basics();
        test_top_target_max_limit();
        test_limit_one();
        test_limit_zero();
        test_input_backpressure();
        test_back_to_back();

        release_request();
        wait_cycles = 0;
        while (expected_results.size() != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never arrived, count", 32'(expected_results.size()),
                            32'd0);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
